// File: hdl/ids_pkg.sv
// Shared types and codes for the interrupt duration statistics block.
`default_nettype none

package ids_pkg;

	// event selector
	localparam logic [1:0] FN_BEGIN = 2'd0;
	localparam logic [1:0] FN_END   = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	// result status
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_DROP     = 2'd1;
	localparam logic [1:0] STAT_NO_START = 2'd2;

	// shared adder operation
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         cpu;
		logic [8:0]         vector;
		logic signed [31:0] owner;
		logic [63:0]        timestamp;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [63:0]        irq_count;
		logic [63:0]        dur_total;
		logic [63:0]        dur_max;
		logic signed [31:0] entry_owner;
		logic [8:0]         active_code;
		logic [63:0]        duration;
	} rsp_item_t;

	// one statistics table entry
	typedef struct packed {
		logic [63:0]        start_time;
		logic [63:0]        completed_count;
		logic [63:0]        cycle_total;
		logic [63:0]        cycle_max;
		logic signed [31:0] owner;
	} entry_t;

endpackage

`default_nettype wire

// File: hdl/ids_alu.sv
// Shared 64-bit add/subtract unit with borrow out.
`default_nettype none

module ids_alu (
	input  wire logic        op,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] result,
	output logic             borrow
);
	import ids_pkg::*;

	logic [64:0] wide;

	always_comb begin
		if (op == ALU_SUB) begin
			wide = {1'b0, a} - {1'b0, b};
		end else begin
			wide = {1'b0, a} + {1'b0, b};
		end
	end

	assign result = wide[63:0];
	// only meaningful for subtract: a < b
	assign borrow = (op == ALU_SUB) ? wide[64] : 1'b0;

endmodule

`default_nettype wire

// File: hdl/ids_table.sv
// Single-write, single-read statistics table with registered read data.
`default_nettype none

module ids_table #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire ids_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output ids_pkg::entry_t      rd_data
);
	import ids_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/irq_duration_statistics_core.sv
// Interrupt duration statistics: one table entry per processor and vector.
//
// Usage: events enter on the req channel (valid/ready) and each produces
// exactly one result transaction on the rsp channel (valid/ready).
// Begin stores owner and start time and marks the vector active on its
// processor; end measures the duration and updates count, total and maximum;
// read returns the entry. Out-of-range processor or vector gives a zeroed
// result with status dropped.
// Steps after acceptance, each ending in the output step: dropped goes there
// directly; read passes lookup; begin, lookup and table write; end without
// start, lookup, subtract and write; completed end, lookup, subtract, total,
// count, maximum and write. The block takes one event at a time; an end event
// makes four passes through the one shared 64-bit adder (duration, total, count, maximum compare).
// Reset: the active marks clear at once; the table is then swept to zero,
// one entry per cycle, all NUM_CPUS*VECTORS entries (2048 at defaults), with
// req_ready low until the sweep ends.
// A stalled receiver holds the finished result in the output register; the
// next event is still accepted and processed, and waits only when its own
// result is ready to go out.
`default_nettype none

module irq_duration_statistics_core #(
	parameter int NUM_CPUS = 8,
	parameter int VECTORS  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire ids_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output ids_pkg::rsp_item_t      rsp
);
	import ids_pkg::*;

	localparam int ENTRIES = NUM_CPUS * VECTORS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IW      = AW + 5;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_LOOK  = 4'd2;
	localparam logic [3:0] ST_SUB   = 4'd3;
	localparam logic [3:0] ST_TOT   = 4'd4;
	localparam logic [3:0] ST_CNT   = 4'd5;
	localparam logic [3:0] ST_MAX   = 4'd6;
	localparam logic [3:0] ST_WRITE = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cpu_q;
	logic [8:0]    vec_q;
	logic [1:0]    func_q;
	logic [63:0]   ts_q;
	logic signed [31:0] owner_q;
	logic          drop_q;
	logic [1:0]    status_q;
	logic [63:0]   dur_q;
	entry_t        ent_q;
	logic [8:0]    active_q [NUM_CPUS];
	logic          rsp_valid_q;
	rsp_item_t     rsp_q;

	logic          accept;
	logic          in_range;
	logic [AW-1:0] req_idx;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	entry_t        mem_wr_data;
	entry_t        mem_rd_data;
	entry_t        look_ent;
	rsp_item_t     rsp_next;
	logic          alu_op;
	logic [63:0]   alu_a;
	logic [63:0]   alu_b;
	logic [63:0]   alu_res;
	logic          alu_borrow;
	logic          out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign in_range  = (32'(req.cpu) < 32'(NUM_CPUS)) && (32'(req.vector) < 32'(VECTORS));
	assign req_idx   = AW'(IW'(req.cpu) * IW'(VECTORS) + IW'(req.vector));
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign mem_wr_en   = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign mem_wr_addr = (state_q == ST_CLEAR) ? clr_q : idx_q;
	assign mem_wr_data = (state_q == ST_CLEAR) ? '0 : ent_q;

	ids_table #(
		.DEPTH(ENTRIES),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (accept && in_range),
		.rd_addr(req_idx),
		.rd_data(mem_rd_data)
	);

	// entry as loaded, with begin's owner and start merged in
	always_comb begin
		look_ent = mem_rd_data;
		if (func_q == FN_BEGIN) begin
			look_ent.owner      = owner_q;
			look_ent.start_time = ts_q;
		end
	end

	always_comb begin
		rsp_next = '0;
		if (drop_q) begin
			rsp_next.status = STAT_DROP;
		end else begin
			rsp_next.status      = status_q;
			rsp_next.irq_count   = ent_q.completed_count;
			rsp_next.dur_total   = ent_q.cycle_total;
			rsp_next.dur_max     = ent_q.cycle_max;
			rsp_next.entry_owner = ent_q.owner;
			rsp_next.active_code = active_q[cpu_q];
			rsp_next.duration    = dur_q;
		end
	end

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			ST_SUB: begin
				alu_op = ALU_SUB;
				alu_a  = ts_q;
				alu_b  = ent_q.start_time;
			end
			ST_TOT: begin
				alu_a = ent_q.cycle_total;
				alu_b = dur_q;
			end
			ST_CNT: begin
				alu_a = ent_q.completed_count;
				alu_b = 64'd1;
			end
			ST_MAX: begin
				// borrow set means max < duration
				alu_op = ALU_SUB;
				alu_a  = ent_q.cycle_max;
				alu_b  = dur_q;
			end
			default: begin
			end
		endcase
	end

	ids_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.result(alu_res),
		.borrow(alu_borrow)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				active_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_range ? ST_LOOK : ST_OUT;
					end
				end
				ST_LOOK: begin
					case (func_q)
						FN_BEGIN: begin
							active_q[cpu_q] <= vec_q + 9'd1;
							state_q         <= ST_WRITE;
						end
						FN_END: begin
							active_q[cpu_q] <= '0;
							state_q         <= ST_SUB;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_SUB: begin
					if (ent_q.start_time == '0 || alu_borrow) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_TOT;
					end
				end
				ST_TOT:   state_q <= ST_CNT;
				ST_CNT:   state_q <= ST_MAX;
				ST_MAX:   state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q    <= req_idx;
					cpu_q    <= req.cpu[CW-1:0];
					vec_q    <= req.vector;
					func_q   <= req.func;
					ts_q     <= req.timestamp;
					owner_q  <= req.owner;
					drop_q   <= !in_range;
					status_q <= in_range ? STAT_DONE : STAT_DROP;
					dur_q    <= '0;
				end
			end
			ST_LOOK: ent_q <= look_ent;
			ST_SUB: begin
				ent_q.start_time <= '0;
				if (ent_q.start_time == '0 || alu_borrow) begin
					status_q <= STAT_NO_START;
				end else begin
					dur_q <= alu_res;
				end
			end
			ST_TOT: ent_q.cycle_total     <= alu_res;
			ST_CNT: ent_q.completed_count <= alu_res;
			ST_MAX: begin
				if (alu_borrow) begin
					ent_q.cycle_max <= dur_q;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_q <= rsp_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("ready stayed high after accepting a transaction");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == STAT_DROP |->
		rsp_q.irq_count == '0 && rsp_q.dur_total == '0 && rsp_q.dur_max == '0 &&
		rsp_q.entry_owner == '0 && rsp_q.active_code == '0 && rsp_q.duration == '0)
		else $error("dropped transaction carries nonzero fields");

	a_max_covers_dur: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == STAT_DONE |-> rsp_q.dur_max >= rsp_q.duration)
		else $error("maximum below measured duration");

endmodule

`default_nettype wire
